@@ rtl/iir_ctl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR controller package
// Shared constants, register indexes and the control word of the shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package iir_ctl_pkg;

  // Default table geometry.
  localparam int TableDepthDef = 32;
  localparam int FreqWidthDef  = 24;

  // Accumulator width: five 32x48 products with 32 fraction bits need 82 bits.
  localparam int AccW = 84;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_FB_COEFF_1  = 3'd0;
  localparam logic [2:0] REG_FB_COEFF_2  = 3'd1;
  localparam logic [2:0] REG_ERR_COEFF_0 = 3'd2;
  localparam logic [2:0] REG_ERR_COEFF_1 = 3'd3;
  localparam logic [2:0] REG_ERR_COEFF_2 = 3'd4;
  localparam logic [2:0] REG_FREQ_COUNT  = 3'd5;

  // Reset value of the current-error weight, 918.0 in Q16.16.
  localparam logic signed [31:0] ErrCoeff0Rst = 32'sd60162048;

  // Chunk selects of the 48-bit operand, 16 bits each.
  localparam logic [1:0] CHUNK_LO  = 2'd0;
  localparam logic [1:0] CHUNK_MID = 2'd1;
  localparam logic [1:0] CHUNK_HI  = 2'd2;

  typedef struct packed {
    logic       clr;     // zero the accumulator
    logic       mul_en;  // a partial product enters the multiplier
    logic       sub;     // subtract this partial product
    logic [1:0] chunk;   // operand chunk, sets the left shift
  } mac_ctrl_t;

endpackage

@@ rtl/iir_ctl_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR controller multiply-accumulate unit
// One 32x17 signed multiplier followed by a registered product and a wide
// accumulator that adds or subtracts the product shifted by its chunk.
// ----------------------------------------------------------------------------
module iir_ctl_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  iir_ctl_pkg::mac_ctrl_t             ctrl_i,
  input  logic signed [31:0]                 coeff_i,
  input  logic signed [16:0]                 chunk_i,
  output logic signed [iir_ctl_pkg::AccW-1:0] acc_o
);

  logic signed [48:0]                  prod_q;
  logic                                vld_q;
  logic                                sub_q;
  logic [1:0]                          chunk_q;
  logic signed [iir_ctl_pkg::AccW-1:0] acc_q;
  logic signed [iir_ctl_pkg::AccW-1:0] prod_ext;
  logic signed [iir_ctl_pkg::AccW-1:0] prod_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= coeff_i * chunk_i;
    sub_q   <= ctrl_i.sub;
    chunk_q <= ctrl_i.chunk;
  end

  always_comb begin
    prod_ext = iir_ctl_pkg::AccW'(prod_q);
    case (chunk_q)
      iir_ctl_pkg::CHUNK_MID: prod_sh = prod_ext <<< 16;
      iir_ctl_pkg::CHUNK_HI:  prod_sh = prod_ext <<< 32;
      default:                prod_sh = prod_ext;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (vld_q) begin
      acc_q <= sub_q ? acc_q - prod_sh : acc_q + prod_sh;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/iir_ctl_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR controller frequency table
// Single-port-write, registered-read table memory. Per-entry valid bits make
// every entry read as zero until it is first written after reset.
// ----------------------------------------------------------------------------
module iir_ctl_table #(
  parameter int Depth = iir_ctl_pkg::TableDepthDef,
  parameter int Width = iir_ctl_pkg::FreqWidthDef,
  localparam int Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/iir_controller_freq_snap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR controller with frequency snap
// Second-order fixed-point controller whose output is snapped to a table of
// ascending frequencies.
// ----------------------------------------------------------------------------
// Usage. Input words arrive on in_valid_i/in_ready_o. A word with action_i
// low is a controller step carrying a Q16.16 error sample; a word with
// action_i high writes table_value_i into table entry table_index_i and
// produces no result. Each step produces exactly one output word, the chosen
// frequency, on out_valid_o/out_ready_i. The user must set coefficients and
// table entry count via the APB port only while the block is idle, unchecked.
// Sequence. A table write is taken while the block is idle and the next word
// may follow right after. A step runs five products, three operand chunks
// each, through the shared 32x17 multiplier, drains the accumulator and
// saturates, scans the table one entry per cycle (1 up to the entry count),
// and then loads the output register; in_ready_o is low after acceptance
// until that load.
// Stalls. The output register holds a result until it is taken; a new word is
// accepted meanwhile, and a following step waits at its end for the register.
// Reset clears the histories, loads the register defaults, and marks every
// table entry as zero through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module iir_controller_freq_snap #(
  parameter int TABLE_DEPTH = iir_ctl_pkg::TableDepthDef,
  parameter int FREQ_WIDTH  = iir_ctl_pkg::FreqWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input words.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [31:0] error_sample_i,
  input  logic [4:0]         table_index_i,
  input  logic [23:0]        table_value_i,
  // Output words.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        chosen_freq_o,
  // APB configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int Aw = $clog2(TABLE_DEPTH);

  // Product terms, in the order the sequencer walks them.
  localparam logic [2:0] TERM_FB1 = 3'd0;
  localparam logic [2:0] TERM_FB2 = 3'd1;
  localparam logic [2:0] TERM_E0  = 3'd2;
  localparam logic [2:0] TERM_E1  = 3'd3;
  localparam logic [2:0] TERM_E2  = 3'd4;

  localparam logic signed [47:0] OutMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] OutMin = {1'b1, {47{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SAT,
    ST_SCAN,
    ST_DONE
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] fb_coeff_1_q;
  logic signed [31:0] fb_coeff_2_q;
  logic signed [31:0] err_coeff_0_q;
  logic signed [31:0] err_coeff_1_q;
  logic signed [31:0] err_coeff_2_q;
  logic [5:0]         freq_count_q;
  logic [2:0]         reg_idx;
  logic               cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_coeff_1_q  <= '0;
      fb_coeff_2_q  <= '0;
      err_coeff_0_q <= iir_ctl_pkg::ErrCoeff0Rst;
      err_coeff_1_q <= '0;
      err_coeff_2_q <= '0;
      freq_count_q  <= 6'd1;
    end else if (cfg_we) begin
      unique case (reg_idx)
        iir_ctl_pkg::REG_FB_COEFF_1:  fb_coeff_1_q  <= pwdata;
        iir_ctl_pkg::REG_FB_COEFF_2:  fb_coeff_2_q  <= pwdata;
        iir_ctl_pkg::REG_ERR_COEFF_0: err_coeff_0_q <= pwdata;
        iir_ctl_pkg::REG_ERR_COEFF_1: err_coeff_1_q <= pwdata;
        iir_ctl_pkg::REG_ERR_COEFF_2: err_coeff_2_q <= pwdata;
        iir_ctl_pkg::REG_FREQ_COUNT:  freq_count_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      iir_ctl_pkg::REG_FB_COEFF_1:  prdata = fb_coeff_1_q;
      iir_ctl_pkg::REG_FB_COEFF_2:  prdata = fb_coeff_2_q;
      iir_ctl_pkg::REG_ERR_COEFF_0: prdata = err_coeff_0_q;
      iir_ctl_pkg::REG_ERR_COEFF_1: prdata = err_coeff_1_q;
      iir_ctl_pkg::REG_ERR_COEFF_2: prdata = err_coeff_2_q;
      iir_ctl_pkg::REG_FREQ_COUNT:  prdata = {26'd0, freq_count_q};
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_e                state_q;
  logic [2:0]            term_q;
  logic [1:0]            chunk_q;
  logic signed [31:0]    e_q;
  logic signed [47:0]    out_hist_1_q;
  logic signed [47:0]    out_hist_2_q;
  logic signed [31:0]    err_hist_1_q;
  logic signed [31:0]    err_hist_2_q;
  logic signed [31:0]    ui_q;
  logic [Aw-1:0]         idx_q;
  logic [Aw-1:0]         last_q;
  logic [FREQ_WIDTH-1:0] prev_q;
  logic [FREQ_WIDTH-1:0] res_q;
  logic                  out_valid_q;
  logic [23:0]           out_data_q;

  logic in_acc;
  logic step_acc;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign step_acc      = in_acc && !action_i;
  assign out_valid_o   = out_valid_q;
  assign chosen_freq_o = out_data_q;

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate unit and its operand selection
  // --------------------------------------------------------------------------
  iir_ctl_pkg::mac_ctrl_t             mac_ctrl;
  logic signed [31:0]                 mac_coeff;
  logic signed [47:0]                 mac_op;
  logic signed [16:0]                 mac_chunk;
  logic signed [iir_ctl_pkg::AccW-1:0] acc;

  always_comb begin
    case (term_q)
      TERM_FB1: begin
        mac_coeff = fb_coeff_1_q;
        mac_op    = out_hist_1_q;
      end
      TERM_FB2: begin
        mac_coeff = fb_coeff_2_q;
        mac_op    = out_hist_2_q;
      end
      TERM_E0: begin
        mac_coeff = err_coeff_0_q;
        mac_op    = 48'(e_q);
      end
      TERM_E1: begin
        mac_coeff = err_coeff_1_q;
        mac_op    = 48'(err_hist_1_q);
      end
      default: begin
        mac_coeff = err_coeff_2_q;
        mac_op    = 48'(err_hist_2_q);
      end
    endcase
    // The lower chunks are unsigned pieces; the top chunk carries the sign.
    case (chunk_q)
      iir_ctl_pkg::CHUNK_LO:  mac_chunk = {1'b0, mac_op[15:0]};
      iir_ctl_pkg::CHUNK_MID: mac_chunk = {1'b0, mac_op[31:16]};
      default:                mac_chunk = {mac_op[47], mac_op[47:32]};
    endcase
  end

  assign mac_ctrl.clr    = step_acc;
  assign mac_ctrl.mul_en = (state_q == ST_MAC);
  assign mac_ctrl.sub    = (term_q == TERM_FB1) || (term_q == TERM_FB2);
  assign mac_ctrl.chunk  = chunk_q;

  iir_ctl_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .coeff_i (mac_coeff),
    .chunk_i (mac_chunk),
    .acc_o   (acc)
  );

  // --------------------------------------------------------------------------
  // Saturation to Q32.16 and integer part truncated toward zero
  // --------------------------------------------------------------------------
  logic [iir_ctl_pkg::AccW-64:0] acc_hi;
  logic                          acc_fits;
  logic signed [47:0]            u_sat;
  logic signed [31:0]            ui_calc;

  always_comb begin
    acc_hi   = acc[iir_ctl_pkg::AccW-1:63];
    acc_fits = (&acc_hi) || !(|acc_hi);
    if (acc_fits) begin
      u_sat = acc[63:16];
    end else if (acc[iir_ctl_pkg::AccW-1]) begin
      u_sat = OutMin;
    end else begin
      u_sat = OutMax;
    end
    // Floor, then step back toward zero for negative values with a fraction.
    ui_calc = u_sat[47:16] + 32'((u_sat[47] && (|u_sat[15:0])) ? 1 : 0);
  end

  // Last valid entry, with the count clamped to one and to the depth.
  logic [Aw-1:0] last_idx;

  always_comb begin
    if (freq_count_q == '0) begin
      last_idx = '0;
    end else if (32'(freq_count_q) > 32'(TABLE_DEPTH)) begin
      last_idx = Aw'(TABLE_DEPTH - 1);
    end else begin
      last_idx = Aw'(32'(freq_count_q) - 32'd1);
    end
  end

  // --------------------------------------------------------------------------
  // Frequency table
  // --------------------------------------------------------------------------
  logic                  tbl_we;
  logic [Aw-1:0]         tbl_waddr;
  logic [FREQ_WIDTH-1:0] tbl_wdata;
  logic [Aw-1:0]         tbl_raddr;
  logic [FREQ_WIDTH-1:0] tbl_rdata;

  assign tbl_we    = in_acc && action_i && (32'(table_index_i) < 32'(TABLE_DEPTH));
  assign tbl_waddr = Aw'(table_index_i);
  assign tbl_wdata = FREQ_WIDTH'(table_value_i);
  // Entry 0 is fetched during saturation; the scan then prefetches the next.
  assign tbl_raddr = (state_q == ST_SAT) ? '0 : Aw'(idx_q + Aw'(1));

  iir_ctl_table #(
    .Depth (TABLE_DEPTH),
    .Width (FREQ_WIDTH)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Scan compares: the integer output against the entry and the midpoint.
  logic signed [33:0]  ui_x;
  logic signed [33:0]  d_x;
  logic signed [33:0]  mean_x;
  logic [FREQ_WIDTH:0] mean_sum;
  logic                lt_d;
  logic                lt_mean;

  always_comb begin
    mean_sum = (FREQ_WIDTH + 1)'(tbl_rdata) + (FREQ_WIDTH + 1)'(prev_q);
    ui_x     = 34'(ui_q);
    d_x      = $signed(34'(tbl_rdata));
    mean_x   = $signed(34'(mean_sum[FREQ_WIDTH:1]));
    lt_d     = ui_x < d_x;
    lt_mean  = ui_x < mean_x;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      term_q       <= TERM_FB1;
      chunk_q      <= iir_ctl_pkg::CHUNK_LO;
      e_q          <= '0;
      out_hist_1_q <= '0;
      out_hist_2_q <= '0;
      err_hist_1_q <= '0;
      err_hist_2_q <= '0;
      ui_q         <= '0;
      idx_q        <= '0;
      last_q       <= '0;
      prev_q       <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // In the final state the output register is reloaded below instead.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (step_acc) begin
            e_q     <= error_sample_i;
            term_q  <= TERM_FB1;
            chunk_q <= iir_ctl_pkg::CHUNK_LO;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (chunk_q == iir_ctl_pkg::CHUNK_HI) begin
            chunk_q <= iir_ctl_pkg::CHUNK_LO;
            if (term_q == TERM_E2) begin
              state_q <= ST_DRAIN;
            end else begin
              term_q <= term_q + 3'd1;
            end
          end else begin
            chunk_q <= chunk_q + 2'd1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          out_hist_2_q <= out_hist_1_q;
          out_hist_1_q <= u_sat;
          err_hist_2_q <= err_hist_1_q;
          err_hist_1_q <= e_q;
          ui_q         <= ui_calc;
          last_q       <= last_idx;
          idx_q        <= '0;
          state_q      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (lt_d) begin
            // First entry above the output: below entry 0 takes entry 0,
            // otherwise the nearer neighbor by the floored midpoint.
            if (idx_q == '0 || !lt_mean) begin
              res_q <= tbl_rdata;
            end else begin
              res_q <= prev_q;
            end
            state_q <= ST_DONE;
          end else if (idx_q == last_q) begin
            res_q   <= tbl_rdata;
            state_q <= ST_DONE;
          end else begin
            prev_q <= tbl_rdata;
            idx_q  <= idx_q + Aw'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= 24'(res_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/iir_ctl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR controller port checker
// Concurrent checks on the top-level ports, bound to every instance.
// ----------------------------------------------------------------------------
module iir_ctl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] chosen_freq_o
);

  // A stalled output word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_freq_o))
    else $error("output word changed or dropped while stalled");

  // A controller step keeps the input closed after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !action_i |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too soon after a step");

  // A table write completes at once and the block stays open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i |=> in_ready_o)
    else $error("table write stalled the input");

  // A new output word only appears at the end of a step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("output word appeared without a step in progress");

endmodule

bind iir_controller_freq_snap iir_ctl_checker u_iir_ctl_checker (.*);

@@ tb/sv/iir_controller_freq_snap_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR controller with frequency snap: self-checking testbench
// Sends controller steps and table writes, with random gaps on the input side
// and random stalls on the output side. A predictor in the testbench computes
// the snapped frequency of every step and compares it with each output word.
// Coefficients and the table entry count are set over APB between phases.
// ----------------------------------------------------------------------------
module iir_controller_freq_snap_test;

  localparam int TableDepth  = iir_ctl_pkg::TableDepthDef;
  // Receiver stalls lengthen a step, so the limit on cycles in which no word
  // moves on any port is set well above the length of a step.
  localparam int StallLimit  = 4000;
  // A table write is taken at once. A step that is still in flight is
  // always covered by an outstanding frequency, so this pause is generous.
  localparam int DrainCycles = 60;
  localparam int IdlePct     = 27;

  localparam logic ActStep       = 1'b0;
  localparam logic ActTableWrite = 1'b1;

  // Index six has no register behind it; writes there must change nothing.
  localparam logic [2:0] RegSpare = 3'd6;

  localparam logic [31:0] QOne  = 32'h0001_0000;
  localparam logic [31:0] QMax  = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin  = 32'h8000_0000;
  localparam logic [23:0] FreqMax = 24'hFF_FFFF;

  localparam logic signed [127:0] OutMax = (128'sd1 <<< 47) - 128'sd1;
  localparam logic signed [127:0] OutMin = -(128'sd1 <<< 47);

  typedef struct packed {
    logic        action;
    logic [31:0] error;
    logic [4:0]  index;
    logic [23:0] value;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [31:0] error_sample;
  logic [4:0]  table_index;
  logic [23:0] table_value;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] chosen_freq;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the registers and of the controller state.
  logic signed [31:0] fb_w1, fb_w2, err_w0, err_w1, err_w2;
  logic [5:0]         entry_count;
  logic signed [47:0] out_prev1, out_prev2;
  logic signed [31:0] err_prev1, err_prev2;
  logic [23:0]        freq_levels [TableDepth];

  // Frequencies that steps already accepted will produce, oldest first.
  logic [23:0] freq_expect [$];
  logic [23:0] freq_want;
  int          mismatches = 0;
  int          stalled_cycles = 0;
  bit          no_gaps = 1'b0;

  iir_controller_freq_snap dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .error_sample_i (error_sample),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .chosen_freq_o  (chosen_freq),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Every product is formed at 128 bits, so the sum of all five is exact.
  function automatic logic signed [127:0] wide_mul(input logic signed [127:0] a,
                                                   input logic signed [127:0] b);
    return a * b;
  endfunction

  // Snap an integer level onto the table. Entries are used as they stand, so
  // an unsorted table follows the same first-entry-above rule.
  function automatic logic [23:0] snap_level(input longint level);
    int     n;
    longint lo_f;
    longint hi_f;
    n = (entry_count == 0) ? 1 : (entry_count > TableDepth) ? TableDepth : int'(entry_count);
    lo_f = freq_levels[0];
    if (level < lo_f) return freq_levels[0];
    for (int i = 1; i < n; i++) begin
      hi_f = freq_levels[i];
      lo_f = freq_levels[i - 1];
      if (level < hi_f) begin
        return (level < (lo_f + hi_f) / 2) ? freq_levels[i - 1] : freq_levels[i];
      end
    end
    return freq_levels[n - 1];
  endfunction

  // One controller step: the exact sum carries 32 fraction bits, the low 16
  // are floored away and the result is clamped to 48 bits signed.
  function automatic logic [23:0] controller_step(input logic signed [31:0] e);
    logic signed [127:0] acc;
    logic signed [47:0]  u;
    longint              whole;
    acc = wide_mul(err_w0, e) + wide_mul(err_w1, err_prev1) + wide_mul(err_w2, err_prev2)
        - wide_mul(fb_w1, out_prev1) - wide_mul(fb_w2, out_prev2);
    acc = acc >>> 16;
    if (acc > OutMax) acc = OutMax;
    else if (acc < OutMin) acc = OutMin;
    u = acc[47:0];
    out_prev2 = out_prev1;
    out_prev1 = u;
    err_prev2 = err_prev1;
    err_prev1 = e;
    // The integer part is truncated toward zero, not floored.
    whole = u;
    if (whole < 0) whole = -((-whole) >>> 16);
    else whole = whole >>> 16;
    return snap_level(whole);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls and the result check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (freq_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("chosen_freq: word with nothing expected, got %0d", chosen_freq);
        end
      end else begin
        freq_want = freq_expect.pop_front();
        if (chosen_freq !== freq_want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("chosen_freq: expected %0d, got %0d", freq_want, chosen_freq);
          end
        end
      end
    end
  end

  // The run is stopped when no word moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= StallLimit) begin
      $display("iir_controller_freq_snap_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one word and hold it until it is taken. A gap lowers valid only
  // before the word is raised, never in the step that raises it.
  task automatic send_word(input word_t w);
    while (!no_gaps && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= w.action;
    error_sample <= w.error;
    table_index  <= w.index;
    table_value  <= w.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.action == ActStep) freq_expect.push_back(controller_step(w.error));
    else freq_levels[w.index] = w.value;
  endtask

  // The fields a word does not use still carry random bits.
  task automatic send_step(input logic [31:0] e);
    send_word('{ActStep, e, 5'($urandom()), 24'($urandom())});
  endtask

  task automatic send_level(input logic [4:0] idx, input logic [23:0] val);
    send_word('{ActTableWrite, $urandom(), idx, val});
  endtask

  // Lower valid and wait for every outstanding frequency plus a margin.
  task automatic settle();
    in_valid <= 1'b0;
    while (freq_expect.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One APB write. Select stays high so that writes can follow back to back;
  // program_regs ends the sequence.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      iir_ctl_pkg::REG_FB_COEFF_1:  fb_w1 = val;
      iir_ctl_pkg::REG_FB_COEFF_2:  fb_w2 = val;
      iir_ctl_pkg::REG_ERR_COEFF_0: err_w0 = val;
      iir_ctl_pkg::REG_ERR_COEFF_1: err_w1 = val;
      iir_ctl_pkg::REG_ERR_COEFF_2: err_w2 = val;
      iir_ctl_pkg::REG_FREQ_COUNT:  entry_count = val[5:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] fb1, input logic [31:0] fb2,
                              input logic [31:0] ec0, input logic [31:0] ec1,
                              input logic [31:0] ec2, input logic [31:0] count);
    reg_write(iir_ctl_pkg::REG_FB_COEFF_1, fb1);
    reg_write(iir_ctl_pkg::REG_FB_COEFF_2, fb2);
    reg_write(iir_ctl_pkg::REG_ERR_COEFF_0, ec0);
    reg_write(iir_ctl_pkg::REG_ERR_COEFF_1, ec1);
    reg_write(iir_ctl_pkg::REG_ERR_COEFF_2, ec2);
    reg_write(iir_ctl_pkg::REG_FREQ_COUNT, count);
    reg_write(RegSpare, $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fill the whole table with an ascending ladder up to about top.
  task automatic load_ladder(input int top);
    int     step_max;
    longint lvl;
    step_max = top / TableDepth + 1;
    lvl = $urandom_range(0, step_max);
    for (int i = 0; i < TableDepth; i++) begin
      send_level(5'(i), 24'(lvl));
      lvl += $urandom_range(0, step_max);
      if (lvl > FreqMax) lvl = FreqMax;
    end
  endtask

  // Mostly errors whose integer part lands across the table, some over the
  // full 32-bit range and some at the extremes.
  function automatic logic [31:0] pick_error(input int span);
    int whole;
    case ($urandom_range(9))
      0: return $urandom();
      1: begin
        case ($urandom_range(3))
          0: return QMax;
          1: return QMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        whole = int'($urandom_range(0, span + span / 4)) - span / 8;
        return {whole[15:0], 16'($urandom())};
      end
    endcase
  endfunction

  // Random steps with a sprinkling of table writes that may unsort the table.
  // With hold_off set, the sender now and then waits for every result.
  task automatic run_mix(input int n_words, input int span, input int top,
                         input bit hold_off);
    for (int k = 0; k < n_words; k++) begin
      if (hold_off && (k % 12) == 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (freq_expect.size() != 0) @(posedge clk);
      end
      if ($urandom_range(4) == 0) begin
        send_level(5'($urandom()),
                   $urandom_range(1) ? 24'($urandom()) : 24'($urandom_range(0, top)));
      end else begin
        send_step(pick_error(span));
      end
    end
  endtask

  function automatic logic [31:0] small_coeff(input int half_range);
    return 32'(int'($urandom_range(0, 2 * half_range)) - half_range);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the table is all zero and the count is one, so every
  // step snaps to zero, while the histories still fill up.
  task automatic test_reset_defaults();
    send_step('0);
    send_step(QOne);
    send_step(QMax);
    send_step(QMin);
    send_step(32'hFFFF_8000);
  endtask

  // Unity gain on a short table: below the first entry, the floored midpoint,
  // an exact entry, beyond the last counted entry, and a negative fraction
  // that must truncate toward zero (0 snaps to 1, -1 snaps to 0).
  task automatic test_snap_rules();
    settle();
    program_regs('0, '0, QOne, '0, '0, 32'd4);
    send_level(5'd0, 24'd0);
    send_level(5'd1, 24'd1);
    send_level(5'd2, 24'd100);
    send_level(5'd3, 24'd200);
    send_level(5'd31, FreqMax);
    send_step(32'hFFFF_8000);
    send_step(32'hFFFF_0000);
    send_step(32'h0096_0000);
    send_step(32'h0095_8000);
    send_step(32'h0064_0000);
    send_step(32'h03E8_0000);
    send_step(QMin);
  endtask

  // The largest feedback weight flips and amplifies the previous output, so
  // the output saturates at both ends. A count of 63 acts as the full table.
  task automatic test_saturation();
    settle();
    program_regs(QMax, '0, QMax, '0, '0, 32'd63);
    repeat (3) send_step(QMax);
    repeat (3) send_step(QMin);
  endtask

  // Unity gain over a full sorted table, with neither side idling.
  task automatic test_unity_gain();
    settle();
    no_gaps = 1'b1;
    program_regs('0, '0, QOne, '0, '0, 32'd32);
    load_ladder(20000);
    run_mix(48, 20000, 20000, 1'b0);
    settle();
    no_gaps = 1'b0;
  endtask

  // Gain of 256 with mild feedback and error history weights.
  task automatic test_high_gain();
    settle();
    program_regs(small_coeff(16384), small_coeff(16384), 32'h0100_0000,
                 small_coeff(1 << 23), small_coeff(1 << 23), $urandom_range(2, 31));
    load_ladder(256 * 20000);
    run_mix(48, 20000, 256 * 20000, 1'b0);
  endtask

  // Fully random weights, mostly saturating, with a count above the table.
  task automatic test_random_coeffs();
    settle();
    program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom_range(33, 63));
    load_ladder(FreqMax);
    run_mix(48, 20000, FreqMax, 1'b0);
  endtask

  // Every weight at an end of its range and a count of zero, which acts as one.
  task automatic test_extreme_coeffs();
    settle();
    program_regs(QMax, QMin, QMin, QMax, QMin, 32'd0);
    load_ladder(FreqMax);
    run_mix(48, 20000, FreqMax, 1'b0);
  endtask

  // A damped filter that uses every history term; the sender pauses now and
  // then until all results are back.
  task automatic test_feedback_with_pauses();
    settle();
    program_regs(32'hFFFF_8000, 32'h0000_4000, QOne, 32'h0000_8000, 32'hFFFF_C000,
                 32'd17);
    load_ladder(20000);
    run_mix(48, 20000, 20000, 1'b1);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    action       = ActStep;
    error_sample = '0;
    table_index  = '0;
    table_value  = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    fb_w1        = '0;
    fb_w2        = '0;
    err_w0       = iir_ctl_pkg::ErrCoeff0Rst;
    err_w1       = '0;
    err_w2       = '0;
    entry_count  = 6'd1;
    out_prev1    = '0;
    out_prev2    = '0;
    err_prev1    = '0;
    err_prev2    = '0;
    for (int i = 0; i < TableDepth; i++) freq_levels[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_snap_rules();
    test_saturation();
    test_unity_gain();
    test_high_gain();
    test_random_coeffs();
    test_extreme_coeffs();
    test_feedback_with_pauses();
    settle();

    if (mismatches == 0 && freq_expect.size() == 0) begin
      $display("iir_controller_freq_snap_test: done, clean");
    end else begin
      $display("iir_controller_freq_snap_test: done, errors");
    end
    $finish;
  end

endmodule

@@ iir_controller_freq_snap.f @@
rtl/iir_ctl_pkg.sv
rtl/iir_ctl_mac.sv
rtl/iir_ctl_table.sv
rtl/iir_controller_freq_snap.sv
rtl/iir_ctl_checker.sv
tb/sv/iir_controller_freq_snap_test.sv
